// ===== rtl/core/ssi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sorted set search and insert block.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int VAL_W    = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic                    command;
    logic signed [VAL_W-1:0] value;
  } ssi_req_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
    logic             inserted;
    logic             table_full;
    logic [CNT_W-1:0] entry_count;
  } ssi_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_DECIDE,
    ST_SHIFT,
    ST_STORE,
    ST_DONE
  } ssi_state_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_cmp;
    logic chk_rd;
    logic chk_cmp;
    logic set_full;
    logic shift_init;
    logic shift_step;
    logic store;
    logic emit;
  } ssi_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic ins_req;
    logic is_full;
    logic shift_last;
  } ssi_stat_t;

endpackage

// ===== rtl/core/sorted_set_search_insert_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_search_insert_top
// Sorted table of distinct signed 32-bit values with lookup and insert.
// ----------------------------------------------------------------------------
// usage:
//   an item (command, value) is taken at a clock edge with start high and
//   busy low. command 0 looks the value up, command 1 inserts it if absent.
//   one result per item appears on result for exactly one cycle with done
//   high; the receiver cannot stall it, so it must take it in that cycle.
// sequence:
//   each binary search probe is a memory read then a compare, and the
//   search ends when the bounds meet; a presence check (read, compare)
//   and a decide step follow. an insert shifts the entries above the
//   position one slot a cycle through the single memory read and write
//   port, then stores the new value. busy stays high through the emit
//   step. done rises in the cycle busy falls.
// reset:
//   rst clears the entry count and the controller; table contents are not
//   cleared, entries at or above the count never reach a result.
// ----------------------------------------------------------------------------
module sorted_set_search_insert_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ssi_pkg::ssi_req_t request,
  output logic              done,
  output ssi_pkg::ssi_res_t result
);
  import ssi_pkg::*;

  ssi_cmd_t  cmd;
  ssi_stat_t stat;

  ssi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ssi_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== rtl/core/ssi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_ctrl
// Sequencer: search steps, presence check, insert shift and result emit.
// ----------------------------------------------------------------------------
module ssi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ssi_pkg::ssi_stat_t stat,
  output ssi_pkg::ssi_cmd_t  cmd
);
  import ssi_pkg::*;

  ssi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (stat.srch_done) begin
          state_next = ST_CHK_RD;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next  = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = ST_SRCH_RD;
      end
      ST_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_next = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        cmd.chk_cmp = 1'b1;
        state_next  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.ins_req && stat.is_full) begin
          cmd.set_full = 1'b1;
          state_next   = ST_DONE;
        end else if (stat.ins_req) begin
          cmd.shift_init = 1'b1;
          state_next     = ST_SHIFT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ssi_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_dp
// Table memory, search bounds, shift pointer, entry count and result register.
// ----------------------------------------------------------------------------
module ssi_dp (
  input  logic               clk,
  input  logic               rst,
  input  ssi_pkg::ssi_req_t  request,
  input  ssi_pkg::ssi_cmd_t  cmd,
  output ssi_pkg::ssi_stat_t stat,
  output logic               done,
  output ssi_pkg::ssi_res_t  result
);
  import ssi_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  ssi_req_t         req_r;
  logic [CNT_W-1:0] lo, hi, mid, count, idx;
  logic [IDX_W-1:0] wr_idx;
  logic             pend;
  logic             found_r, inserted_r, full_r;

  logic [CNT_W-1:0] mid_next, idx_dec;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data;

  assign mid_next = lo + ((hi - lo) >> 1);
  assign idx_dec  = idx - CNT_W'(1);

  assign stat.srch_done  = (lo == hi);
  assign stat.ins_req    = req_r.command & ~found_r;
  assign stat.is_full    = (count == CAP_CNT);
  assign stat.shift_last = (idx == lo);

  // read port: search probe, presence check, or the next entry to move up
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_next[IDX_W-1:0];
    if (cmd.srch_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid_next[IDX_W-1:0];
    end else if (cmd.chk_rd) begin
      rd_en   = 1'b1;
      rd_addr = lo[IDX_W-1:0];
    end else if (cmd.shift_step && !stat.shift_last) begin
      rd_en   = 1'b1;
      rd_addr = idx_dec[IDX_W-1:0];
    end
  end

  // write port: entry read last cycle lands one slot higher, or the new value
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx;
    wr_data = rdata;
    if (cmd.store) begin
      wr_en   = 1'b1;
      wr_addr = lo[IDX_W-1:0];
      wr_data = req_r.value;
    end else if (cmd.shift_step && pend) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= request;
      lo         <= '0;
      hi         <= count;
      found_r    <= 1'b0;
      inserted_r <= 1'b0;
      full_r     <= 1'b0;
    end
    if (cmd.srch_rd) begin
      mid <= mid_next;
    end
    if (cmd.srch_cmp) begin
      if ($signed(rdata) < req_r.value) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.chk_cmp) begin
      found_r <= (lo < count) && (rdata == req_r.value);
    end
    if (cmd.set_full) begin
      full_r <= 1'b1;
    end
    if (cmd.shift_init) begin
      idx <= count;
    end
    if (cmd.shift_step && !stat.shift_last) begin
      wr_idx <= idx[IDX_W-1:0];
      idx    <= idx_dec;
    end
    if (cmd.store) begin
      inserted_r <= 1'b1;
    end
    if (cmd.emit) begin
      result.found       <= found_r;
      result.position    <= lo;
      result.inserted    <= inserted_r;
      result.table_full  <= full_r;
      result.entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.store) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.shift_init) begin
        pend <= 1'b0;
      end else if (cmd.shift_step) begin
        pend <= !stat.shift_last;
      end
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_ins_not_found: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.inserted && (result.found || result.table_full)))
    else $error("inserted result also flagged found or full");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (result.entry_count == CAP_CNT))
    else $error("full flag with table not full");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.position <= result.entry_count))
    else $error("position beyond entry count");

  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (count == $past(count) + CNT_W'(1)))
    else $error("store did not grow the count");

endmodule
